FILE: rtl/length_prefixed_deframer_macros.svh
// Assertion macros used by the deframer top file.
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define LPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/lpd_pkg.sv
package lpd_pkg;

  localparam int unsigned LENGTH_WIDTH = 32;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HDR_POS_W    = $clog2(HEADER_BYTES);
  localparam int unsigned HDR_W        = 8 * HEADER_BYTES;

  localparam int unsigned USER_FIRST = 0;
  localparam int unsigned USER_EMPTY = 1;

  typedef logic [LENGTH_WIDTH-1:0] len_t;
  typedef logic [HDR_POS_W-1:0]    hdr_pos_t;

  typedef struct packed {
    logic [31:0] frame_length;
    logic [31:0] message_id;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic        empty_frame;
  } result_t;

endpackage

FILE: rtl/lpd_parse.sv
module lpd_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_data,
  output logic             res_valid,
  output lpd_pkg::result_t res
);

  logic                      accept;
  lpd_pkg::hdr_pos_t         hdr_pos;
  lpd_pkg::hdr_pos_t         hdr_pos_next;
  logic                      in_payload;
  logic                      in_payload_next;
  logic                      first;
  logic                      first_next;
  lpd_pkg::len_t             left;
  lpd_pkg::len_t             left_next;
  logic [lpd_pkg::HDR_W-1:0] hdr;
  logic [lpd_pkg::HDR_W-1:0] hdr_next;
  lpd_pkg::len_t             len_now;
  logic                      hdr_done;
  logic                      pay_last;

  assign accept = in_valid && in_ready;

  always_comb begin
    hdr_next = hdr;
    if (!in_payload) begin
      hdr_next[{hdr_pos, 3'b000} +: 8] = in_data;
    end
    len_now  = hdr_next[lpd_pkg::LENGTH_WIDTH-1:0];
    hdr_done = (hdr_pos == lpd_pkg::hdr_pos_t'(lpd_pkg::HEADER_BYTES - 1));
    pay_last = (left <= lpd_pkg::len_t'(1));

    hdr_pos_next    = hdr_pos;
    in_payload_next = in_payload;
    first_next      = first;
    left_next       = left;

    res.payload_byte = in_data;
    res.message_id   = hdr_next[lpd_pkg::HDR_W-1:32];
    res.frame_length = 32'(len_now);
    res.first_byte   = first;
    res.last_byte    = pay_last;
    res.empty_frame  = 1'b0;
    res_valid        = 1'b0;

    if (in_payload) begin
      res_valid  = in_valid;
      first_next = 1'b0;
      left_next  = left - lpd_pkg::len_t'(1);
      if (pay_last) begin
        in_payload_next = 1'b0;
        hdr_pos_next    = '0;
      end
    end else if (hdr_done) begin
      hdr_pos_next = '0;
      if (len_now == '0) begin
        // A zero-length frame is reported once, on its last header byte.
        res_valid        = in_valid;
        res.payload_byte = 8'd0;
        res.first_byte   = 1'b0;
        res.last_byte    = 1'b1;
        res.empty_frame  = 1'b1;
      end else begin
        in_payload_next = 1'b1;
        first_next      = 1'b1;
        left_next       = len_now;
      end
    end else begin
      hdr_pos_next = hdr_pos + lpd_pkg::hdr_pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= '0;
      in_payload <= 1'b0;
      first      <= 1'b0;
      left       <= '0;
    end else if (accept) begin
      hdr_pos    <= hdr_pos_next;
      in_payload <= in_payload_next;
      first      <= first_next;
      left       <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= hdr_next;
    end
  end

endmodule

FILE: rtl/lpd_obuf.sv
module lpd_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  lpd_pkg::result_t up_data,
  output logic             up_ready,
  output logic             out_valid,
  output lpd_pkg::result_t out_data,
  input  logic             dn_ready
);

  logic             skid_valid;
  lpd_pkg::result_t skid_data;
  logic             up_fire;

  assign up_ready = !skid_valid;
  assign up_fire  = up_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (dn_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= up_fire;
      end
    end else if (up_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= up_data;
      end
    end else if (up_fire) begin
      skid_data <= up_data;
    end
  end

endmodule

FILE: rtl/length_prefixed_deframer.sv
// Channel  Direction  tdata (low bit up)                       tuser / tlast
// s_axis   in         data_byte[7:0]                           none
// m_axis   out        payload_byte, message_id, frame_length   first_byte, empty_frame / last
//
// Each input byte is handled in the cycle it is accepted, one per clock while s_axis_tready is high.
// A result is registered in the output buffer before it appears on m_axis.
// A two-entry output buffer keeps s_axis_tready registered; under an output stall it drops once both entries fill.
// Reset clears the header position, the payload counter and the valid flags of both buffer entries.
`include "length_prefixed_deframer_macros.svh"

module length_prefixed_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // payload_byte[7:0], message_id[39:8], frame_length[71:40]
  output logic [1:0]  m_axis_tuser,   // first_byte[0], empty_frame[1]
  output logic        m_axis_tlast
);

  logic             res_valid;
  lpd_pkg::result_t res;
  lpd_pkg::result_t out_res;

  lpd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (res_valid),
    .up_data   (res),
    .up_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .dn_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.frame_length, out_res.message_id, out_res.payload_byte};
  assign m_axis_tuser[lpd_pkg::USER_FIRST] = out_res.first_byte;
  assign m_axis_tuser[lpd_pkg::USER_EMPTY] = out_res.empty_frame;
  assign m_axis_tlast = out_res.last_byte;

  `LPD_ASSERT_IMP(a_empty_shape, clk, rst, m_axis_tvalid && m_axis_tuser[lpd_pkg::USER_EMPTY], m_axis_tlast && !m_axis_tuser[lpd_pkg::USER_FIRST] && (m_axis_tdata[71:40] == 32'd0), "Empty frame result is malformed.")
  `LPD_ASSERT_IMP(a_ready_drop, clk, rst, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready), "Input ready dropped without an output stall.")
  `LPD_ASSERT_NXT(a_skid_drain, clk, rst, !s_axis_tready && m_axis_tready, s_axis_tready && m_axis_tvalid, "Buffered result did not drain.")

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AFTER = 300;
  localparam int unsigned RANDOM_BYTES = 880;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Tracks the framing state of the stream and holds the results it implies.
  class frame_scoreboard;
    lpd_pkg::result_t pending_results[$];
    logic [3:0]  hdr_count;
    logic [63:0] hdr_bytes;
    logic [31:0] bytes_left;
    logic [31:0] bytes_seen;
    bit          in_payload;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned bytes_noted;
    int unsigned frames_seen;
    int unsigned empty_frames;

    function new();
      hdr_count = '0;
      hdr_bytes = '0;
      bytes_left = '0;
      bytes_seen = '0;
      in_payload = 1'b0;
      mismatches = 0;
      results_checked = 0;
      bytes_noted = 0;
      frames_seen = 0;
      empty_frames = 0;
    endfunction

    function logic [31:0] current_length();
      logic [63:0] mask;
      mask = (64'd1 << lpd_pkg::LENGTH_WIDTH) - 64'd1;
      return hdr_bytes[31:0] & mask[31:0];
    endfunction

    function void note_byte(logic [7:0] data);
      lpd_pkg::result_t r;
      logic [31:0] len;
      bytes_noted++;
      if (!in_payload) begin
        hdr_bytes[8 * hdr_count[2:0] +: 8] = data;
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == lpd_pkg::HEADER_BYTES) begin
          frames_seen++;
          len = current_length();
          if (len == 32'd0) begin
            r = '{frame_length: 32'd0, message_id: hdr_bytes[63:32], payload_byte: 8'd0,
                  first_byte: 1'b0, last_byte: 1'b1, empty_frame: 1'b1};
            pending_results = {pending_results, r};
            empty_frames++;
            hdr_count = '0;
            hdr_bytes = '0;
          end else begin
            in_payload = 1'b1;
            bytes_left = len;
            bytes_seen = '0;
          end
        end
      end else begin
        r = '{frame_length: current_length(), message_id: hdr_bytes[63:32],
              payload_byte: data, first_byte: (bytes_seen == 32'd0),
              last_byte: (bytes_left <= 32'd1), empty_frame: 1'b0};
        pending_results = {pending_results, r};
        bytes_seen = bytes_seen + 32'd1;
        if (bytes_left != 32'd0) bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          in_payload = 1'b0;
          bytes_seen = '0;
          hdr_count = '0;
          hdr_bytes = '0;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(lpd_pkg::result_t got);
      lpd_pkg::result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("Unexpected output transaction: payload_byte 0x%0h", got.payload_byte);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      results_checked++;
      compare_field("payload_byte", exp_r.payload_byte, got.payload_byte);
      compare_field("message_id", exp_r.message_id, got.message_id);
      compare_field("frame_length", exp_r.frame_length, got.frame_length);
      compare_field("first_byte", exp_r.first_byte, got.first_byte);
      compare_field("last_byte", exp_r.last_byte, got.last_byte);
      compare_field("empty_frame", exp_r.empty_frame, got.empty_frame);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  frame_scoreboard sb = new();
  int unsigned     longest_hold;

  length_prefixed_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(data);
  endtask

  task automatic send_header(logic [31:0] len, logic [31:0] id);
    for (int k = 0; k < 4; k++) send_byte(len[8 * k +: 8]);
    for (int k = 0; k < 4; k++) send_byte(id[8 * k +: 8]);
  endtask

  task automatic send_random_frame();
    int unsigned roll;
    logic [31:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 10) len = 32'd0;
    else if (roll < 70) len = $urandom_range(1, 8);
    else if (roll < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(100, 300);
    send_header(len, $urandom);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Output side: random back-pressure plus one long hold-off that fills the block.
  initial begin
    int unsigned idle_left;
    bit          held;
    idle_left = 0;
    held = 1'b0;
    longest_hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.results_checked >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        longest_hold = HOLD_OFF_CYCLES;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        m_axis_tready <= 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    lpd_pkg::result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.payload_byte = m_axis_tdata[7:0];
      got.message_id = m_axis_tdata[39:8];
      got.frame_length = m_axis_tdata[71:40];
      got.first_byte = m_axis_tuser[lpd_pkg::USER_FIRST];
      got.empty_frame = m_axis_tuser[lpd_pkg::USER_EMPTY];
      got.last_byte = m_axis_tlast;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timed out after %0d cycles without a transaction.", WATCHDOG_LIMIT);
    $display("length_prefixed_deframer verification failed");
    $finish;
  end

  initial begin
    logic [31:0] huge_len;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty frame with an all-ones id, single-byte frame, two-byte frame.
    send_header(32'd0, 32'hFFFF_FFFF);
    send_header(32'd1, 32'd0);
    send_byte(8'h00);
    send_header(32'd2, 32'h1234_5678);
    send_byte(8'hFF);
    send_byte(8'h80);

    while (sb.bytes_noted < RANDOM_BYTES) send_random_frame();

    // A frame whose length has its top bit set is left open at the end of the stream.
    huge_len = {8'($urandom_range(128, 255)), 24'($urandom)};
    send_header(huge_len, $urandom);
    repeat (30) send_byte(8'($urandom_range(0, 255)));

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d headers (%0d empty frames), checked %0d results,",
             sb.bytes_noted, sb.frames_seen, sb.empty_frames, sb.results_checked);
    $display("including a %0d-cycle output hold-off and an open frame of length 0x%0h.",
             longest_hold, huge_len);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("length_prefixed_deframer verification clean");
    end else begin
      $display("length_prefixed_deframer verification failed");
    end
    $finish;
  end
endmodule
